FILE: hw/rtl/hcs_pkg.sv
package hcs_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VTX_W        = 4;
  localparam int CNT_W        = 5;
  localparam int ROW_W        = 16;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;
  localparam int REG_IDX_W    = 2;

  localparam logic [CNT_W-1:0]     VC_RESET         = 5'd4;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;

  typedef struct packed {
    logic             found;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } hcs_res_t;

endpackage

FILE: hw/rtl/hcs_req_if.sv
interface hcs_req_if import hcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] row_index;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output row_index, output row_bits, input ready);
  modport sink (input valid, input row_index, input row_bits, output ready);
endinterface

FILE: hw/rtl/hcs_res_if.sv
interface hcs_res_if import hcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [VTX_W-1:0] vertex;
  logic             last;

  modport source (output valid, output found, output vertex, output last, input ready);
  modport sink (input valid, input found, input vertex, input last, output ready);
endinterface

FILE: hw/rtl/hcs_cfg_regs.sv
module hcs_cfg_regs import hcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CNT_W-1:0]   n_o
);

  logic [CNT_W-1:0]     vc_q, vc_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == REG_VERTEX_COUNT);

  always_comb begin
    vc_d = vc_q;
    if (wr_en) begin
      vc_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_RESET;
    end else begin
      vc_q <= vc_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_VERTEX_COUNT) begin
      prdata = PDATA_W'(vc_q);
    end
  end

  // clamp to 1..MAX_VERTICES
  always_comb begin
    n_o = vc_q;
    if (vc_q == '0) begin
      n_o = CNT_W'(1);
    end else if (vc_q > CNT_W'(MAX_VERTICES)) begin
      n_o = CNT_W'(MAX_VERTICES);
    end
  end

endmodule

FILE: hw/rtl/hcs_result_reg.sv
module hcs_result_reg import hcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  input  hcs_res_t res_i,
  output logic     res_ready_o,
  hcs_res_if.source res_o
);

  logic     valid_q, valid_d;
  hcs_res_t data_q;

  assign res_ready_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid  = valid_q;
  assign res_o.found  = data_q.found;
  assign res_o.vertex = data_q.vertex;
  assign res_o.last   = data_q.last;

endmodule

FILE: hw/rtl/hcs_search_core.sv
module hcs_search_core import hcs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] n_i,
  hcs_req_if.sink          req_i,
  output logic             res_valid_o,
  output hcs_res_t         res_o,
  input  logic             res_ready_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADJ_RD = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_POP    = 3'd3;
  localparam logic [2:0] ST_OUT_RD = 3'd4;
  localparam logic [2:0] ST_OUT_LD = 3'd5;
  localparam logic [2:0] ST_FAIL   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] depth_q, depth_d;
  logic [ROW_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] start_q, start_d;
  logic [VTX_W-1:0] top_q, top_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  logic [ROW_W-1:0] adj_mem [MAX_VERTICES];
  logic             adj_we, adj_re;
  logic [ROW_W-1:0] adj_rdata_q;

  logic [VTX_W-1:0] stk_mem [MAX_VERTICES];
  logic             stk_we, stk_re;
  logic [VTX_W-1:0] stk_waddr, stk_wdata, stk_raddr;
  logic [VTX_W-1:0] stk_rdata_q;

  logic             req_fire;
  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] depth_m2;
  logic [ROW_W-1:0] cand;
  logic [VTX_W-1:0] pick;
  logic             idx_last;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign n_m1        = n_i - CNT_W'(1);
  assign depth_m2    = depth_q - CNT_W'(2);
  assign idx_last    = (idx_q == n_i);

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[req_i.row_index] <= req_i.row_bits;
    end
    if (adj_re) begin
      adj_rdata_q <= adj_mem[top_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      cand[j] = adj_rdata_q[j] && !used_q[j] &&
                (CNT_W'(j) >= start_q) && (CNT_W'(j) < n_i);
    end
  end

  always_comb begin
    pick = '0;
    for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = VTX_W'(j);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    used_d      = used_q;
    start_d     = start_q;
    top_d       = top_q;
    idx_d       = idx_q;
    adj_we      = 1'b0;
    adj_re      = 1'b0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = depth_q[VTX_W-1:0];
    stk_wdata   = pick;
    stk_raddr   = depth_m2[VTX_W-1:0];
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          adj_we = 1'b1;
          if (req_i.row_index == n_m1[VTX_W-1:0]) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
            used_d    = ROW_W'(1);
            depth_d   = CNT_W'(1);
            top_d     = '0;
            start_d   = CNT_W'(1);
            state_d   = ST_ADJ_RD;
          end
        end
      end
      ST_ADJ_RD: begin
        adj_re  = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (depth_q == n_i && adj_rdata_q[0]) begin
          depth_d = '0;
          used_d  = '0;
          idx_d   = '0;
          state_d = ST_OUT_RD;
        end else if (depth_q != n_i && cand != '0) begin
          // advance
          stk_we  = 1'b1;
          used_d  = used_q | (ROW_W'(1) << pick);
          depth_d = depth_q + CNT_W'(1);
          top_d   = pick;
          start_d = CNT_W'(1);
          state_d = ST_ADJ_RD;
        end else if (depth_q == CNT_W'(1)) begin
          depth_d = '0;
          used_d  = '0;
          state_d = ST_FAIL;
        end else begin
          // backtrack
          depth_d = depth_q - CNT_W'(1);
          start_d = CNT_W'(top_q) + CNT_W'(1);
          used_d  = used_q & ~(ROW_W'(1) << top_q);
          stk_re  = 1'b1;
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        top_d   = stk_rdata_q;
        state_d = ST_ADJ_RD;
      end
      ST_OUT_RD: begin
        stk_re    = 1'b1;
        stk_raddr = idx_last ? '0 : idx_q[VTX_W-1:0];
        state_d   = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        res_valid_o  = 1'b1;
        res_o.found  = 1'b1;
        res_o.vertex = stk_rdata_q;
        res_o.last   = idx_last;
        if (res_ready_i) begin
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      ST_FAIL: begin
        res_valid_o = 1'b1;
        res_o.last  = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      depth_q <= '0;
      used_q  <= '0;
      start_q <= '0;
      top_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      used_q  <= used_d;
      start_q <= start_d;
      top_q   <= top_d;
      idx_q   <= idx_d;
    end
  end

endmodule

FILE: hw/rtl/hamiltonian_cycle_search.sv
// Hamiltonian cycle search. Each request on req_i writes one adjacency row, one per
// cycle while req_i.ready is high. The request that writes row vertex_count-1 starts
// a depth-first backtracking search from vertex 0 that runs out of an adjacency RAM
// and a path-stack RAM, both with registered reads; req_i.ready stays low until the
// whole answer has been handed to the result register. Each step deeper passes
// through an adjacency read and a candidate evaluation, and each step back through
// evaluation, stack read and adjacency read, so the search time depends on the
// graph. A found cycle is delivered as vertex_count+1 results, each through a stack
// read and a load, the path followed by vertex 0 with last set; no cycle gives one
// result with found low and last set. The next row request is taken while the final
// result still waits in the result register. Write vertex_count (byte address 0)
// only while the block is idle; values are clamped to 1..16.
module hamiltonian_cycle_search import hcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  hcs_req_if.sink            req_i,
  hcs_res_if.source          res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CNT_W-1:0] n_eff;
  logic             core_valid;
  hcs_res_t         core_res;
  logic             core_ready;

  hcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_o     (n_eff)
  );

  hcs_search_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .req_i       (req_i),
    .res_valid_o (core_valid),
    .res_o       (core_res),
    .res_ready_i (core_ready)
  );

  hcs_result_reg u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (core_valid),
    .res_i       (core_res),
    .res_ready_o (core_ready),
    .res_o       (res_o)
  );

endmodule
